### hdl/cblm_pkg.sv
// ----------------------------------------------------------------------------
// CAN bus load monitor package
// Shared types, constants and lookup functions for the bus load monitor.
// ----------------------------------------------------------------------------
package cblm_pkg;

  localparam int unsigned NumChannels  = 3;
  localparam int unsigned NumWindows   = 3;
  localparam int unsigned ChW          = 2;
  localparam int unsigned TsW          = 32;
  localparam int unsigned FbW          = 8;
  localparam int unsigned LoadW        = 10;
  localparam int unsigned CntW         = 32;
  localparam int unsigned PermilleFull = 1000;
  localparam int unsigned RateSingle   = 33;
  localparam int unsigned RateHigh     = 500;
  localparam int unsigned CapW         = 19;
  localparam int unsigned ProdW        = 29;
  localparam int unsigned DivSteps     = 10;
  localparam int unsigned StepW        = $clog2(DivSteps);
  localparam int unsigned WinW         = 2;
  localparam int unsigned KW           = $clog2(NumChannels * NumWindows);
  localparam int unsigned ChIdxW       = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam logic [WinW-1:0] WinShort = 2'd0;
  localparam logic [WinW-1:0] WinMid   = 2'd1;
  localparam logic [WinW-1:0] WinLong  = 2'd2;

  localparam logic [ChW-1:0] SwcReset = 2'd2;

  typedef struct packed {
    logic [ChW-1:0] channel;
    logic [TsW-1:0] now_ms;
    logic [FbW-1:0] frame_bits;
  } cblm_in_t;

  typedef struct packed {
    logic [ChW-1:0]   result_channel;
    logic [LoadW-1:0] load_short;
    logic [LoadW-1:0] load_mid;
    logic [LoadW-1:0] load_long;
    logic [LoadW-1:0] peak_load;
    logic [CntW-1:0]  bits_short;
    logic [CntW-1:0]  bits_mid;
    logic [CntW-1:0]  bits_long;
  } cblm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACCUM,
    ST_PREP,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } cblm_state_e;

  typedef struct packed {
    logic load_item;
    logic check;
    logic accum;
    logic prep;
    logic div_step;
    logic store;
    logic emit;
  } cblm_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic full;
    logic win_last;
  } cblm_status_t;

  function automatic logic [TsW-1:0] span_of(logic [WinW-1:0] w);
    logic [TsW-1:0] s;
    case (w)
      WinShort: s = TsW'(10);
      WinMid:   s = TsW'(100);
      WinLong:  s = TsW'(1000);
      default:  s = TsW'(1000);
    endcase
    return s;
  endfunction

  // Bits a window can carry at full load: rate times span.
  function automatic logic [CapW-1:0] cap_of(logic single, logic [WinW-1:0] w);
    logic [CapW-1:0] c;
    case (w)
      WinShort: c = single ? CapW'(RateSingle * 10)   : CapW'(RateHigh * 10);
      WinMid:   c = single ? CapW'(RateSingle * 100)  : CapW'(RateHigh * 100);
      WinLong:  c = single ? CapW'(RateSingle * 1000) : CapW'(RateHigh * 1000);
      default:  c = single ? CapW'(RateSingle * 1000) : CapW'(RateHigh * 1000);
    endcase
    return c;
  endfunction

endpackage

### hdl/cblm_datapath.sv
// ----------------------------------------------------------------------------
// CAN bus load monitor datapath
// Window state, saturating counters, shared restoring divider and result
// register.
// ----------------------------------------------------------------------------
module cblm_datapath
  import cblm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cblm_in_t     in_item_i,
  input  logic [ChW-1:0] swc_i,
  input  cblm_cmd_t    cmd_i,
  output cblm_status_t status_o,
  output cblm_out_t    result_o
);

  logic [TsW-1:0]   begin_q [NumChannels*NumWindows];
  logic [CntW-1:0]  count_q [NumChannels*NumWindows];
  logic [LoadW-1:0] peak_store_q [NumChannels];

  logic [ChW-1:0]   ch_q;
  logic [TsW-1:0]   now_q;
  logic [FbW-1:0]   fb_q;
  logic             single_q;
  logic [WinW-1:0]  w_q;
  logic             restart_q;
  logic [CntW-1:0]  cur_q;
  logic [CapW-1:0]  cap_q;
  logic [ProdW-1:0] rem_q;
  logic [ProdW-1:0] dsr_q;
  logic [LoadW-1:0] quo_q;
  logic [LoadW-1:0] load_q [NumWindows];
  logic [CntW-1:0]  bits_q [NumWindows];
  logic [LoadW-1:0] peak_q;
  cblm_out_t        result_q;

  logic [ChIdxW-1:0] chi_in;
  logic [ChIdxW-1:0] chi;
  logic [KW-1:0]     k;
  logic [CntW:0]     sum;
  logic [CntW-1:0]   new_cnt;
  logic              full;
  logic              ge;
  logic [LoadW-1:0]  ld;

  assign chi_in = ChIdxW'(in_item_i.channel - 2'd1);
  assign chi    = ChIdxW'(ch_q - 2'd1);
  assign k      = KW'(chi) * KW'(NumWindows) + KW'(w_q);

  assign sum     = {1'b0, (restart_q ? {CntW{1'b0}} : count_q[k])} + (CntW + 1)'(fb_q);
  assign new_cnt = sum[CntW] ? '1 : sum[CntW-1:0];

  assign full = cur_q >= CntW'(cap_q);
  assign ge   = rem_q >= dsr_q;
  assign ld   = full ? LoadW'(PermilleFull) : quo_q;

  assign status_o.ch_ok    = (in_item_i.channel != '0) &&
                             (32'(in_item_i.channel) <= NumChannels);
  assign status_o.full     = full;
  assign status_o.win_last = (32'(w_q) == NumWindows - 1);

  // Window state and peaks clear at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels * NumWindows; i++) begin
        begin_q[i] <= '0;
        count_q[i] <= '0;
      end
      for (int i = 0; i < NumChannels; i++) begin
        peak_store_q[i] <= '0;
      end
    end else begin
      if (cmd_i.accum) begin
        count_q[k] <= new_cnt;
        if (restart_q) begin
          begin_q[k] <= now_q;
        end
      end
      if (cmd_i.emit) begin
        peak_store_q[chi] <= peak_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      ch_q     <= in_item_i.channel;
      now_q    <= in_item_i.now_ms;
      fb_q     <= in_item_i.frame_bits;
      single_q <= (in_item_i.channel == swc_i);
      w_q      <= WinShort;
      peak_q   <= peak_store_q[chi_in];
    end
    if (cmd_i.check) begin
      restart_q <= (now_q - begin_q[k]) >= span_of(w_q);
    end
    if (cmd_i.accum) begin
      cur_q     <= new_cnt;
      bits_q[w_q] <= new_cnt;
      cap_q     <= cap_of(single_q, w_q);
    end
    if (cmd_i.prep) begin
      // Below capacity the count fits in CapW bits, so the product stays small.
      rem_q <= ProdW'(cur_q[CapW-1:0]) * ProdW'(PermilleFull);
      dsr_q <= ProdW'({cap_q, {(DivSteps-1){1'b0}}});
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      quo_q <= {quo_q[LoadW-2:0], ge};
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.store) begin
      load_q[w_q] <= ld;
      if (ld > peak_q) begin
        peak_q <= ld;
      end
      w_q <= w_q + 1'b1;
    end
    if (cmd_i.emit) begin
      result_q.result_channel <= ch_q;
      result_q.load_short     <= load_q[WinShort];
      result_q.load_mid       <= load_q[WinMid];
      result_q.load_long      <= load_q[WinLong];
      result_q.peak_load      <= peak_q;
      result_q.bits_short     <= bits_q[WinShort];
      result_q.bits_mid       <= bits_q[WinMid];
      result_q.bits_long      <= bits_q[WinLong];
    end
  end

  assign result_o = result_q;

endmodule

### hdl/cblm_ctrl.sv
// ----------------------------------------------------------------------------
// CAN bus load monitor controller
// Sequences the three windows of one item and owns both handshakes.
// ----------------------------------------------------------------------------
module cblm_ctrl
  import cblm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  cblm_status_t status_i,
  output cblm_cmd_t    cmd_o
);

  cblm_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // An item for a channel that does not exist is taken and dropped.
        if (in_valid_i && status_i.ch_ok) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_PREP;
      end
      ST_PREP: begin
        if (status_i.full) begin
          state_d = ST_STORE;
        end else begin
          cmd_o.prep = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (32'(step_q) == DivSteps - 1) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = status_i.win_last ? ST_OUT : ST_CHECK;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/can_bus_load_monitor.sv
// ----------------------------------------------------------------------------
// CAN bus load monitor
// Per-channel bus load over 10, 100 and 1000 ms tumbling windows with a peak.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | cblm_in_t  in_item_i
//  out     | output    | out_valid_o / out_ready_i | cblm_out_t out_item_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | single-wire channel number
//
//  Each window of an item is checked, accumulated, prepared, divided in the
//  shared divider and stored; a saturated window skips the divider. The
//  result is offered in the same cycle as the next item can be taken. An item
//  for a non-existent channel is taken and gives no result. Reset clears all
//  window state and peaks at once. A new item is taken while a result waits;
//  its own result is then held until the earlier one is taken.
// ----------------------------------------------------------------------------
module can_bus_load_monitor
  import cblm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cblm_in_t       in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cblm_out_t      out_item_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [ChW-1:0] cfg_data_i
);

  logic [ChW-1:0] swc_q;
  cblm_cmd_t      cmd;
  cblm_status_t   status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swc_q <= SwcReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      swc_q <= cfg_data_i;
    end
  end

  cblm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cblm_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .swc_i     (swc_q),
    .cmd_i     (cmd),
    .status_o  (status),
    .result_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  // A real item keeps the block busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && status.ch_ok |=> !in_ready_o)
    else $error("input taken again straight after a valid item");

  a_peak_covers_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.peak_load >= out_item_o.load_short &&
                    out_item_o.peak_load >= out_item_o.load_mid &&
                    out_item_o.peak_load >= out_item_o.load_long)
    else $error("peak load below a window load");

  a_result_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.result_channel != '0 &&
                    32'(out_item_o.result_channel) <= NumChannels &&
                    32'(out_item_o.peak_load) <= PermilleFull)
    else $error("result for a channel that does not exist or load above full");
`endif

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// CAN bus load monitor testbench
// Sends bus events through the input channel under random idling on both sides
// and checks every load report against a cycle-free model of the three
// tumbling windows, the permille loads and the per-channel peak. Every
// single-wire channel setting is used, from 0 to 3.
// ----------------------------------------------------------------------------
module tb;
  import cblm_pkg::*;

  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned PhaseItems   = 270;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  cblm_in_t        in_item_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  cblm_out_t       out_item_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [ChW-1:0]  cfg_data_i  = SwcReset;

  can_bus_load_monitor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model state: window start times and bit counts per channel and window,
  // peak load per channel and the single-wire channel setting.
  logic [CntW-1:0]  win_begin_model [NumChannels*NumWindows];
  logic [CntW-1:0]  win_count_model [NumChannels*NumWindows];
  logic [LoadW-1:0] channel_peak [NumChannels];
  logic [ChW-1:0]   swc_model = SwcReset;

  cblm_in_t  pending_frames [$];
  cblm_out_t load_reports [$];
  cblm_out_t report_now;
  cblm_out_t report_due;

  logic [TsW-1:0] time_cursor [NumChannels+1];
  bit             steady = 1'b0;
  int             hold_req = 0;
  int             hold_ack;
  int             hold_left;
  int             take_gap;
  int             send_gap;
  int             gap_draw;
  bit             ready_next;

  int quiet_cycles    = 0;
  int fail_count      = 0;
  int frames_accepted = 0;
  int ignored_count   = 0;
  int results_checked = 0;
  int full_reports    = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  // Advances the window model by one event and returns the report it yields.
  function automatic cblm_out_t predict_load(cblm_in_t ev);
    cblm_out_t        rep;
    int unsigned      base;
    int unsigned      k;
    int unsigned      span;
    int unsigned      rate;
    int unsigned      cap;
    int               w;
    logic [TsW-1:0]   elapsed;
    logic [63:0]      scaled;
    logic [LoadW-1:0] load [NumWindows];
    logic [LoadW-1:0] peak;
    base = (int'(ev.channel) - 1) * NumWindows;
    rate = (ev.channel == swc_model) ? RateSingle : RateHigh;
    peak = channel_peak[int'(ev.channel) - 1];
    for (w = 0; w < NumWindows; w++) begin
      span = (w == 0) ? 10 : (w == 1) ? 100 : 1000;
      k = base + w;
      elapsed = ev.now_ms - win_begin_model[k];
      if (elapsed >= span) begin
        win_begin_model[k] = ev.now_ms;
        win_count_model[k] = '0;
      end
      if (32'hFFFF_FFFF - win_count_model[k] >= 32'(ev.frame_bits))
        win_count_model[k] = win_count_model[k] + 32'(ev.frame_bits);
      else
        win_count_model[k] = 32'hFFFF_FFFF;
      cap = rate * span;
      if (win_count_model[k] >= cap) begin
        load[w] = LoadW'(PermilleFull);
      end else begin
        scaled  = 64'(win_count_model[k]) * 64'(PermilleFull) / 64'(cap);
        load[w] = scaled[LoadW-1:0];
      end
      if (load[w] > peak) peak = load[w];
    end
    channel_peak[int'(ev.channel) - 1] = peak;
    rep.result_channel = ev.channel;
    rep.load_short     = load[0];
    rep.load_mid       = load[1];
    rep.load_long      = load[2];
    rep.peak_load      = peak;
    rep.bits_short     = win_count_model[base];
    rep.bits_mid       = win_count_model[base + 1];
    rep.bits_long      = win_count_model[base + 2];
    return rep;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic compare_report(input cblm_out_t want, input cblm_out_t got);
    check_field("result_channel", 32'(want.result_channel), 32'(got.result_channel));
    check_field("load_short", 32'(want.load_short), 32'(got.load_short));
    check_field("load_mid", 32'(want.load_mid), 32'(got.load_mid));
    check_field("load_long", 32'(want.load_long), 32'(got.load_long));
    check_field("peak_load", 32'(want.peak_load), 32'(got.peak_load));
    check_field("bits_short", want.bits_short, got.bits_short);
    check_field("bits_mid", want.bits_mid, got.bits_mid);
    check_field("bits_long", want.bits_long, got.bits_long);
  endtask

  // Sender: offers the next pending item after a random gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_frames.size() != 0) begin
        in_item_i  <= pending_frames.pop_front();
        in_valid_i <= 1'b1;
        send_gap   <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random gaps after each report, and one long hold on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      take_gap    <= 0;
      hold_left   <= 0;
      hold_ack    <= 0;
    end else begin
      ready_next = 1'b1;
      if (hold_ack != hold_req) begin
        hold_ack   <= hold_req;
        hold_left  <= HoldCycles;
        ready_next = 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        ready_next = 1'b0;
      end else if (take_gap > 0) begin
        take_gap   <= take_gap - 1;
        ready_next = 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        gap_draw = pick_gap();
        if (gap_draw > 0) begin
          take_gap   <= gap_draw - 1;
          ready_next = 1'b0;
        end
      end
      out_ready_i <= ready_next;
    end
  end

  // Monitor: reports are checked before the item of the same edge is modelled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (load_reports.size() == 0) begin
          fail_count++;
          $display("%0t: report for channel %0d with no item waiting", $time,
                   out_item_o.result_channel);
        end else begin
          report_due = load_reports.pop_front();
          compare_report(report_due, out_item_o);
          results_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (in_item_i.channel == 0 || in_item_i.channel > NumChannels) begin
          ignored_count++;
        end else begin
          report_now = predict_load(in_item_i);
          load_reports.push_back(report_now);
          frames_accepted++;
          if (report_now.load_short == PermilleFull || report_now.load_mid == PermilleFull)
            full_reports++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) swc_model = cfg_data_i;
    end
  end

  task automatic add_frame(input logic [ChW-1:0] ch, input logic [TsW-1:0] stamp,
                           input logic [FbW-1:0] bits);
    cblm_in_t ev;
    ev.channel    = ch;
    ev.now_ms     = stamp;
    ev.frame_bits = bits;
    pending_frames.push_back(ev);
  endtask

  // Mostly small time steps per channel, with floods of frames in one
  // millisecond to reach full load, rare long jumps and stray channel zero.
  task automatic queue_random(input int count);
    int               n;
    int               r;
    int               flood_left;
    logic [ChW-1:0]   ch;
    logic [TsW-1:0]   step;
    logic [FbW-1:0]   bits;
    flood_left = 0;
    ch = 2'd1;
    for (n = 0; n < count; n++) begin
      if (flood_left > 0) begin
        flood_left--;
        step = '0;
        bits = FbW'($urandom_range(200, 255));
      end else begin
        ch = ChW'($urandom_range(1, NumChannels));
        if ($urandom_range(0, 99) < 4) flood_left = $urandom_range(20, 40);
        r = $urandom_range(0, 99);
        if (r < 35)      step = '0;
        else if (r < 70) step = $urandom_range(1, 4);
        else if (r < 88) step = $urandom_range(5, 60);
        else if (r < 97) step = $urandom_range(61, 1500);
        else             step = $urandom;
        r = $urandom_range(0, 99);
        if (r < 10)      bits = '0;
        else if (r < 55) bits = FbW'($urandom_range(180, 255));
        else             bits = FbW'($urandom_range(0, 255));
      end
      time_cursor[ch] = time_cursor[ch] + step;
      add_frame(ch, time_cursor[ch], bits);
      if ($urandom_range(0, 49) == 0) add_frame(2'd0, $urandom, FbW'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    while (pending_frames.size() != 0 || in_valid_i || load_reports.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_single_wire(input logic [ChW-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    while (quiet_cycles < IdleLimit) @(posedge clk_i);
    $display("Timeout: no handshake for %0d cycles", IdleLimit);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    foreach (win_begin_model[i]) begin
      win_begin_model[i] = '0;
      win_count_model[i] = '0;
    end
    foreach (channel_peak[i]) channel_peak[i] = '0;
    foreach (time_cursor[i]) time_cursor[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed events under the reset setting, channel 2 being single-wire.
    add_frame(2'd1, 32'd0, 8'd0);
    add_frame(2'd1, 32'd0, 8'd255);
    add_frame(2'd1, 32'd5, 8'd255);
    add_frame(2'd1, 32'd10, 8'd255);
    add_frame(2'd2, 32'd0, 8'd255);
    add_frame(2'd2, 32'd0, 8'd255);
    add_frame(2'd2, 32'd3, 8'd0);
    add_frame(2'd0, 32'd123, 8'd77);
    add_frame(2'd3, 32'hFFFF_FFFF, 8'd255);
    add_frame(2'd3, 32'd0, 8'd255);
    add_frame(2'd3, 32'd9, 8'd128);
    add_frame(2'd3, 32'd1000, 8'd1);
    add_frame(2'd3, 32'd999, 8'd200);
    add_frame(2'd0, 32'hFFFF_FFFF, 8'd255);
    add_frame(2'd1, 32'd99, 8'd255);
    add_frame(2'd1, 32'd100, 8'd255);
    add_frame(2'd1, 32'd1000, 8'd0);
    add_frame(2'd1, 32'h8000_0000, 8'd255);
    add_frame(2'd1, 32'h7FFF_FFFF, 8'hAA);
    add_frame(2'd2, 32'hAAAA_AAAA, 8'h55);
    add_frame(2'd2, 32'h5555_5555, 8'hAA);
    add_frame(2'd0, 32'd0, 8'd0);
    add_frame(2'd2, 32'h5555_5555, 8'd255);
    add_frame(2'd3, 32'hFFFF_FFF0, 8'd1);
    wait_idle();

    // No single-wire channel at all.
    write_single_wire(2'd0);
    queue_random(PhaseItems);
    wait_idle();

    // The receiver holds off for a long stretch while items keep coming.
    write_single_wire(2'd3);
    hold_req = hold_req + 1;
    queue_random(PhaseItems);
    wait_idle();

    // Back-to-back items and reports, no idling on either side.
    write_single_wire(2'd1);
    steady = 1'b1;
    queue_random(PhaseItems);
    wait_idle();
    steady = 1'b0;

    write_single_wire(2'd2);
    queue_random(PhaseItems);
    wait_idle();

    write_single_wire(2'd3);
    queue_random(PhaseItems);
    wait_idle();

    $display("Run covered %0d events on three channels and %0d ignored ones,",
             frames_accepted, ignored_count);
    $display("single-wire settings 0 to 3, %0d reports checked, %0d at full load.",
             results_checked, full_reports);
    if (fail_count == 0 && load_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
